/* hw/rtl/tgpe_pkg.sv */
// Shared types, constants and helper functions of the glyph row pixel expander.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tgpe_pkg;

    localparam int GLYPH_WIDTH      = 8;
    localparam int GLYPH_HEIGHT_DEF = 16;
    localparam int COL_W            = 8;
    localparam int ROW_W            = 7;
    localparam int LINE_W           = 4;
    localparam int ATTR_W           = 8;
    localparam int PITCH_W          = 14;
    localparam int ADDR_W           = 32;
    localparam int PIXEL_W          = 32;
    localparam int RGB_W            = 24;
    localparam int BCNT_W           = 3;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_IDX_W        = 2;
    localparam int COL_OFF_W        = 13;
    localparam int QUEUE_DEPTH      = 2;
    localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(4096);

    typedef enum logic [1:0] {
        FMT_32 = 2'd0,
        FMT_24 = 2'd1,
        FMT_16 = 2'd2,
        FMT_15 = 2'd3
    } pix_fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_BASE   = 2'd0,
        CFG_LINE_PITCH   = 2'd1,
        CFG_PIXEL_FORMAT = 2'd2,
        CFG_DISPLAY_OFF  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  frame_base;
        logic [PITCH_W-1:0] line_pitch;
        pix_fmt_t           pixel_format;
        logic               display_off;
    } cfg_t;

    // One glyph row ready to be expanded into pixel writes.
    typedef struct packed {
        logic [ADDR_W-1:0]      start_addr;
        logic [RGB_W-1:0]       fg;
        logic [RGB_W-1:0]       bg;
        logic [GLYPH_WIDTH-1:0] bits;
        logic [BCNT_W-1:0]      bpp;
    } desc_t;

    localparam logic [RGB_W-1:0] PALETTE [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5000, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    function automatic logic [RGB_W-1:0] pack_colour(input logic [RGB_W-1:0] rgb,
                                                     input pix_fmt_t fmt);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [RGB_W-1:0] res;
        r = rgb[23:16];
        g = rgb[15:8];
        b = rgb[7:0];
        unique case (fmt)
            FMT_32:  res = rgb;
            FMT_24:  res = rgb;
            FMT_16:  res = {8'h00, r[7:3], g[7:2], b[7:3]};
            FMT_15:  res = {8'h00, 1'b0, r[7:3], g[7:3], b[7:3]};
            default: res = rgb;
        endcase
        return res;
    endfunction

    function automatic logic [BCNT_W-1:0] bytes_per_pixel(input pix_fmt_t fmt);
        logic [BCNT_W-1:0] res;
        unique case (fmt)
            FMT_32:  res = BCNT_W'(4);
            FMT_24:  res = BCNT_W'(3);
            FMT_16:  res = BCNT_W'(2);
            FMT_15:  res = BCNT_W'(2);
            default: res = BCNT_W'(2);
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/text_glyph_row_pixel_expander.sv */
// Text glyph row pixel expander: each accepted glyph row (eight font bits with
// cell position, glyph line, attribute and cursor flag) becomes eight pixel
// writes on the result channel, leftmost pixel first, each with a framebuffer
// byte address, a packed colour, a byte count and a last-pixel flag.
// Both channels are valid/ready; the configuration port is a plain write
// port (cfg_wr_en, cfg_index, cfg_wdata) and may only be written while idle.
// A row passes the front-end stage, the queue and the sequencer before its
// first pixel reaches the output register. Throughput: one pixel write per
// cycle while m_ready is high, set by the back end's single-pixel output
// register. Rows without output (display off, empty cursor row) are dropped.
// A two-entry descriptor queue parts the front end from the pixel sequencer,
// so new rows are taken while earlier rows are still being written out.
// When the receiver stalls, the current pixel holds on the outputs and the
// front end keeps accepting until the queue and its stage register fill.
// Synchronous active-low reset empties all stages and restores the register
// defaults: base 0, pitch 4096, 32 bpp, display on.
// Depends on tgpe_pkg, tgpe_front, tgpe_queue and tgpe_back.
`default_nettype none

module text_glyph_row_pixel_expander
    import tgpe_pkg::*;
#(
    parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [COL_W-1:0]       s_cell_column,
    input  wire logic [ROW_W-1:0]       s_cell_row,
    input  wire logic [LINE_W-1:0]      s_glyph_line,
    input  wire logic [GLYPH_WIDTH-1:0] s_glyph_bits,
    input  wire logic [ATTR_W-1:0]      s_attribute,
    input  wire logic                   s_is_cursor,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [ADDR_W-1:0]           m_byte_address,
    output logic [PIXEL_W-1:0]          m_pixel_value,
    output logic [BCNT_W-1:0]           m_byte_count,
    output logic                        m_last_pixel
);

    cfg_t  cfg_reg, cfg_next;
    logic  q_wr_valid;
    logic  q_wr_ready;
    desc_t q_wr_data;
    logic  q_rd_valid;
    logic  q_rd_pop;
    desc_t q_rd_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FRAME_BASE:   cfg_next.frame_base   = cfg_wdata[ADDR_W-1:0];
                CFG_LINE_PITCH:   cfg_next.line_pitch   = cfg_wdata[PITCH_W-1:0];
                CFG_PIXEL_FORMAT: cfg_next.pixel_format = pix_fmt_t'(cfg_wdata[1:0]);
                CFG_DISPLAY_OFF:  cfg_next.display_off  = cfg_wdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_base   <= '0;
            cfg_reg.line_pitch   <= PITCH_RESET;
            cfg_reg.pixel_format <= FMT_32;
            cfg_reg.display_off  <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tgpe_front #(
        .GLYPH_HEIGHT (GLYPH_HEIGHT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cell_column (s_cell_column),
        .s_cell_row    (s_cell_row),
        .s_glyph_line  (s_glyph_line),
        .s_glyph_bits  (s_glyph_bits),
        .s_attribute   (s_attribute),
        .s_is_cursor   (s_is_cursor),
        .q_wr_valid    (q_wr_valid),
        .q_wr_ready    (q_wr_ready),
        .q_wr_data     (q_wr_data)
    );

    tgpe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_pop   (q_rd_pop),
        .rd_data  (q_rd_data)
    );

    tgpe_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_rd_valid     (q_rd_valid),
        .q_rd_pop       (q_rd_pop),
        .q_rd_data      (q_rd_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_address (m_byte_address),
        .m_pixel_value  (m_pixel_value),
        .m_byte_count   (m_byte_count),
        .m_last_pixel   (m_last_pixel)
    );

    // The sequencer only takes a descriptor that the queue actually holds.
    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_rd_pop |-> q_rd_valid)
        else $error("descriptor popped from an empty queue");

    // Pixels of one row follow each other without a gap once one is taken.
    a_row_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_pixel) |=> m_valid)
        else $error("gap inside a glyph row");

    a_byte_count_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_byte_count == 3'd2 || m_byte_count == 3'd3 || m_byte_count == 3'd4))
        else $error("illegal byte count on a pixel write");

    // A full queue must hold the front end back.
    a_queue_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_wr_valid && !q_wr_ready) |-> !s_ready)
        else $error("input accepted while the queue is full");

endmodule

`default_nettype wire

/* hw/rtl/tgpe_front.sv */
// Front end: accepts glyph rows, drops the ones that produce no writes, and
// computes start address and packed colours. Depends on tgpe_pkg.
`default_nettype none

module tgpe_front
    import tgpe_pkg::*;
#(
    parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cfg_t                   cfg,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [COL_W-1:0]       s_cell_column,
    input  wire logic [ROW_W-1:0]       s_cell_row,
    input  wire logic [LINE_W-1:0]      s_glyph_line,
    input  wire logic [GLYPH_WIDTH-1:0] s_glyph_bits,
    input  wire logic [ATTR_W-1:0]      s_attribute,
    input  wire logic                   s_is_cursor,
    output logic                        q_wr_valid,
    input  wire logic                   q_wr_ready,
    output desc_t                       q_wr_data
);

    localparam int SCAN_W = $clog2(((1 << ROW_W) * GLYPH_HEIGHT) + (1 << LINE_W));
    localparam int PROD_W = SCAN_W + PITCH_W;

    logic                   st_valid_reg, st_valid_next;
    logic [PROD_W-1:0]      st_prod_reg;
    logic [COL_OFF_W-1:0]   st_coloff_reg;
    logic [RGB_W-1:0]       st_fg_reg;
    logic [RGB_W-1:0]       st_bg_reg;
    logic [GLYPH_WIDTH-1:0] st_bits_reg;
    logic [BCNT_W-1:0]      st_bpp_reg;

    logic                   accept;
    logic                   keep;
    logic [SCAN_W-1:0]      scan;
    logic [PROD_W-1:0]      prod;
    logic [BCNT_W-1:0]      bpp;
    logic [COL_OFF_W-1:0]   coloff;

    assign s_ready = !st_valid_reg || q_wr_ready;
    assign accept  = s_valid && s_ready;

    // Blanked display and empty cursor rows leave no trace past this point.
    assign keep = !cfg.display_off && !(s_is_cursor && (s_glyph_bits == '0));

    assign scan   = SCAN_W'(s_cell_row) * SCAN_W'(GLYPH_HEIGHT) + SCAN_W'(s_glyph_line);
    assign prod   = PROD_W'(scan) * PROD_W'(cfg.line_pitch);
    assign bpp    = bytes_per_pixel(cfg.pixel_format);
    assign coloff = COL_OFF_W'(s_cell_column) * COL_OFF_W'(GLYPH_WIDTH) * COL_OFF_W'(bpp);

    always_comb begin
        st_valid_next = st_valid_reg;
        if (accept) begin
            st_valid_next = keep;
        end else if (q_wr_ready) begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_prod_reg   <= prod;
            st_coloff_reg <= coloff;
            st_fg_reg     <= pack_colour(PALETTE[s_attribute[3:0]], cfg.pixel_format);
            st_bg_reg     <= pack_colour(PALETTE[{1'b0, s_attribute[6:4]}], cfg.pixel_format);
            st_bits_reg   <= s_glyph_bits;
            st_bpp_reg    <= bpp;
        end
    end

    assign q_wr_valid           = st_valid_reg;
    assign q_wr_data.start_addr = cfg.frame_base + ADDR_W'(st_prod_reg)
                                + ADDR_W'(st_coloff_reg);
    assign q_wr_data.fg         = st_fg_reg;
    assign q_wr_data.bg         = st_bg_reg;
    assign q_wr_data.bits       = st_bits_reg;
    assign q_wr_data.bpp        = st_bpp_reg;

endmodule

`default_nettype wire

/* hw/rtl/tgpe_queue.sv */
// Short descriptor queue between the front end and the pixel sequencer.
// Depends on tgpe_pkg.
`default_nettype none

module tgpe_queue
    import tgpe_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  wr_valid,
    output logic       wr_ready,
    input  wire desc_t wr_data,
    output logic       rd_valid,
    input  wire logic  rd_pop,
    output desc_t      rd_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t            entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;
    assign rd_data  = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tgpe_back.sv */
// Back end: expands one queued glyph row into eight pixel writes, leftmost
// first, through a registered output stage. Depends on tgpe_pkg.
`default_nettype none

module tgpe_back
    import tgpe_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_rd_valid,
    output logic                   q_rd_pop,
    input  wire desc_t             q_rd_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [ADDR_W-1:0]      m_byte_address,
    output logic [PIXEL_W-1:0]     m_pixel_value,
    output logic [BCNT_W-1:0]      m_byte_count,
    output logic                   m_last_pixel
);

    localparam int IDX_W = $clog2(GLYPH_WIDTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GLYPH_WIDTH - 1);

    logic                   busy_reg, busy_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [ADDR_W-1:0]      addr_reg;
    logic [RGB_W-1:0]       fg_reg;
    logic [RGB_W-1:0]       bg_reg;
    logic [GLYPH_WIDTH-1:0] bits_reg;
    logic [BCNT_W-1:0]      bpp_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]      out_addr_reg;
    logic [PIXEL_W-1:0]     out_pixel_reg;
    logic [BCNT_W-1:0]      out_bcnt_reg;
    logic                   out_last_reg;

    logic                   adv;
    logic                   at_last;

    // A pixel moves into the output register whenever that register is free
    // or being drained in the same cycle.
    assign adv      = busy_reg && (!out_valid_reg || m_ready);
    assign at_last  = (idx_reg == LAST_IDX);
    assign q_rd_pop = q_rd_valid && (!busy_reg || (adv && at_last));

    always_comb begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (adv) begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 1'b1;
            if (at_last) begin
                busy_next = 1'b0;
            end
        end
        if (q_rd_pop) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_addr_reg  <= addr_reg;
            out_pixel_reg <= PIXEL_W'(bits_reg[GLYPH_WIDTH-1] ? fg_reg : bg_reg);
            out_bcnt_reg  <= bpp_reg;
            out_last_reg  <= at_last;
        end
        // A new row loaded on the last pixel of the previous one replaces the
        // shifted address and bits.
        if (q_rd_pop) begin
            addr_reg <= q_rd_data.start_addr;
            fg_reg   <= q_rd_data.fg;
            bg_reg   <= q_rd_data.bg;
            bits_reg <= q_rd_data.bits;
            bpp_reg  <= q_rd_data.bpp;
        end else if (adv) begin
            addr_reg <= addr_reg + ADDR_W'(bpp_reg);
            bits_reg <= {bits_reg[GLYPH_WIDTH-2:0], 1'b0};
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_byte_address = out_addr_reg;
    assign m_pixel_value  = out_pixel_reg;
    assign m_byte_count   = out_bcnt_reg;
    assign m_last_pixel   = out_last_reg;

endmodule

`default_nettype wire
